### hdl/nonoverlap_pattern_occurrence_counter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the occurrence counter
// ----------------------------------------------------------------------------
`ifndef NONOVERLAP_PATTERN_OCCURRENCE_COUNTER_DEFINES_SVH
`define NONOVERLAP_PATTERN_OCCURRENCE_COUNTER_DEFINES_SVH

// Property checked on every rising edge outside of reset.
`define NOPOC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define NOPOC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/nopoc_pkg.sv
// ----------------------------------------------------------------------------
// nopoc_pkg
// Widths and register indexes of the non-overlapping occurrence counter.
// ----------------------------------------------------------------------------
package nopoc_pkg;

    localparam int SYM_BITS     = 8;
    localparam int SYM_SLOTS    = 8;
    localparam int SLOT_BITS    = 3;
    localparam int PATTERN_BITS = SYM_BITS * SYM_SLOTS;
    localparam int LEN_BITS     = 4;
    localparam int WINDOW_BITS  = 16;
    localparam int OUT_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd1000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PATTERN = 2'd0,
        CFG_LENGTH  = 2'd1,
        CFG_WINDOW  = 2'd2
    } cfg_index_t;

endpackage

### hdl/nopoc_ram.sv
// ----------------------------------------------------------------------------
// nopoc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nopoc_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/nonoverlap_pattern_occurrence_counter.sv
// Steps: idle, head, tail (only on a level-0 match), a walk over levels 1..L-1 (L =
// clamped pattern length), then final; head goes straight to final for L = 1 or once
// the sequence has overflowed. A new symbol is taken only when idle, and a finished
// result waits in the final state for m_ready. Reset: aresetn (synchronous, active low)
// clears control, the pattern and the per-level valid bits and loads the default length
// and window; an invalid level reads as zero, and the last symbol clears the bits too.
// ----------------------------------------------------------------------------
// nonoverlap_pattern_occurrence_counter
// Counts non-overlapping occurrences of a configured symbol pattern.
// ----------------------------------------------------------------------------
module nonoverlap_pattern_occurrence_counter #(
    parameter int MAX_PATTERN = 8,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [nopoc_pkg::SYM_BITS-1:0]        s_symbol,
    input  logic                                  s_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [nopoc_pkg::OUT_BITS-1:0]        m_occurrence_count,
    output logic                                  m_overflow,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [nopoc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [nopoc_pkg::PATTERN_BITS-1:0]    cfg_data
);

    import nopoc_pkg::*;

    localparam int LVL_BITS = $clog2(MAX_PATTERN);
    localparam int LEN_CAP  = (MAX_PATTERN < SYM_SLOTS) ? MAX_PATTERN : SYM_SLOTS;
    localparam int EXT_BITS = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
    localparam logic [EXT_BITS-1:0] OUT_MAX = EXT_BITS'((1 << OUT_BITS) - 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HEAD = 5'b00010,
        ST_TAIL = 5'b00100,
        ST_WALK = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    typedef logic [COUNT_BITS-1:0] cnt_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    state_t                   state_reg, state_next;
    logic [PATTERN_BITS-1:0]  pattern_reg, pattern_next;
    logic [LEN_BITS-1:0]      length_reg, length_next;
    logic [WINDOW_BITS-1:0]   window_reg, window_next;
    logic [SYM_BITS-1:0]      sym_reg, sym_next;
    logic                     last_reg, last_next;
    logic [LEN_BITS-1:0]      len_reg, len_next;
    logic [SLOT_BITS-1:0]     lvl_reg, lvl_next;
    logic                     took_reg, took_next;
    cnt_t                     prev_reg, prev_next;
    cnt_t                     c0_reg, c0_next;
    logic                     ovf_reg, ovf_next;
    logic [MAX_PATTERN-1:0]   valid_reg, valid_next;
    logic                     rd_valid_reg;
    logic                     m_valid_reg, m_valid_next;
    logic [OUT_BITS-1:0]      m_count_reg, m_count_next;
    logic                     m_ovf_reg, m_ovf_next;

    logic                     ram_we;
    logic [LVL_BITS-1:0]      ram_waddr, ram_raddr;
    cnt_t                     ram_wdata, ram_rdata;

    logic [LEN_BITS-1:0]      len_eff;
    logic [SLOT_BITS-1:0]     len_m1, lvl_m1, lvl_p1;
    cnt_t                     rd_cnt, cnt_inc, lead;
    logic [SYM_BITS-1:0]      pat_cur, pat_prev;
    logic [COUNT_BITS:0]      need;
    logic [EXT_BITS-1:0]      prev_ext;
    logic                     s_fire, out_free;

    nopoc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_PATTERN)
    ) u_lvl_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid            = m_valid_reg;
    assign m_occurrence_count = m_count_reg;
    assign m_overflow         = m_ovf_reg;

    // Clamp the programmed length to 1..min(8, MAX_PATTERN).
    always_comb begin
        if (length_reg == '0) begin
            len_eff = LEN_BITS'(1);
        end else if (length_reg > LEN_BITS'(LEN_CAP)) begin
            len_eff = LEN_BITS'(LEN_CAP);
        end else begin
            len_eff = length_reg;
        end
    end

    assign len_m1   = len_reg[SLOT_BITS-1:0] - SLOT_BITS'(1);
    assign lvl_m1   = lvl_reg - SLOT_BITS'(1);
    assign lvl_p1   = lvl_reg + SLOT_BITS'(1);
    assign pat_cur  = pattern_reg[{lvl_reg, 3'b000} +: SYM_BITS];
    assign pat_prev = pattern_reg[{lvl_m1, 3'b000} +: SYM_BITS];

    // Levels never written in this sequence read as zero.
    assign rd_cnt   = rd_valid_reg ? ram_rdata : '0;
    assign cnt_inc  = sat_inc(rd_cnt);
    assign lead     = c0_reg - rd_cnt;
    assign need     = {1'b0, rd_cnt}
                    + (COUNT_BITS + 1)'((pat_cur == pat_prev) && took_reg);
    assign prev_ext = EXT_BITS'(prev_reg);

    always_comb begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        window_next  = window_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PATTERN: pattern_next = cfg_data;
                CFG_LENGTH:  length_next  = cfg_data[LEN_BITS-1:0];
                CFG_WINDOW:  window_next  = cfg_data[WINDOW_BITS-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        sym_next     = sym_reg;
        last_next    = last_reg;
        len_next     = len_reg;
        lvl_next     = lvl_reg;
        took_next    = took_reg;
        prev_next    = prev_reg;
        c0_next      = c0_reg;
        ovf_next     = ovf_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_count_next = m_count_reg;
        m_ovf_next   = m_ovf_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = cnt_inc;
        ram_raddr    = '0;

        case (state_reg)
            ST_IDLE: begin
                // Level 0 is read while idle, so it is ready in the head state.
                if (s_fire) begin
                    sym_next   = s_symbol;
                    last_next  = s_last;
                    len_next   = len_eff;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (len_reg == LEN_BITS'(1)) begin
                    prev_next = rd_cnt;
                    if (sym_reg == pattern_reg[SYM_BITS-1:0]) begin
                        ram_we    = 1'b1;
                        prev_next = cnt_inc;
                        valid_next[0] = 1'b1;
                    end
                    state_next = ST_FIN;
                end else if (ovf_reg) begin
                    state_next = ST_FIN;
                end else if (sym_reg == pattern_reg[SYM_BITS-1:0]) begin
                    c0_next    = rd_cnt;
                    ram_raddr  = LVL_BITS'(len_m1);
                    state_next = ST_TAIL;
                end else begin
                    prev_next  = rd_cnt;
                    took_next  = 1'b0;
                    lvl_next   = SLOT_BITS'(1);
                    ram_raddr  = LVL_BITS'(1);
                    state_next = ST_WALK;
                end
            end
            ST_TAIL: begin
                // Freeze the sequence once level 0 leads the last level too far.
                if (c0_reg >= rd_cnt
                    && EXT_BITS'(lead) >= EXT_BITS'(window_reg)) begin
                    ovf_next   = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    ram_we        = 1'b1;
                    ram_wdata     = sat_inc(c0_reg);
                    valid_next[0] = 1'b1;
                    prev_next     = sat_inc(c0_reg);
                    took_next     = 1'b1;
                    lvl_next      = SLOT_BITS'(1);
                    ram_raddr     = LVL_BITS'(1);
                    state_next    = ST_WALK;
                end
            end
            ST_WALK: begin
                prev_next = rd_cnt;
                if (sym_reg == pat_cur) begin
                    if ({1'b0, prev_reg} > need) begin
                        ram_we    = 1'b1;
                        ram_waddr = LVL_BITS'(lvl_reg);
                        valid_next[LVL_BITS'(lvl_reg)] = 1'b1;
                        prev_next = cnt_inc;
                        took_next = 1'b1;
                    end else begin
                        took_next = 1'b0;
                    end
                end
                if (lvl_reg == len_m1) begin
                    state_next = ST_FIN;
                end else begin
                    lvl_next   = lvl_p1;
                    ram_raddr  = LVL_BITS'(lvl_p1);
                end
            end
            ST_FIN: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ovf_next   = ovf_reg;
                    if (ovf_reg) begin
                        m_count_next = '0;
                    end else if (prev_ext > OUT_MAX) begin
                        m_count_next = OUT_MAX[OUT_BITS-1:0];
                    end else begin
                        m_count_next = prev_ext[OUT_BITS-1:0];
                    end
                    // Drop all level counts for the next sequence.
                    valid_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pattern_reg  <= '0;
            length_reg   <= LEN_BITS'(1);
            window_reg   <= WINDOW_RESET;
            ovf_reg      <= 1'b0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pattern_reg  <= pattern_next;
            length_reg   <= length_next;
            window_reg   <= window_next;
            ovf_reg      <= ovf_next;
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[ram_raddr];
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg     <= sym_next;
        last_reg    <= last_next;
        len_reg     <= len_next;
        lvl_reg     <= lvl_next;
        took_reg    <= took_next;
        prev_reg    <= prev_next;
        c0_reg      <= c0_next;
        m_count_reg <= m_count_next;
        m_ovf_reg   <= m_ovf_next;
    end

endmodule

### hdl/nopoc_checker.sv
// ----------------------------------------------------------------------------
// nopoc_checker
// Port-level checks on the occurrence counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "nonoverlap_pattern_occurrence_counter_defines.svh"

module nopoc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [nopoc_pkg::OUT_BITS-1:0]    m_occurrence_count,
    input logic                              m_overflow
);

    import nopoc_pkg::*;

    `NOPOC_ASSERT(a_no_result_after_reset, aclk, aresetn, !$past(aresetn) |-> !m_valid, "result valid right after reset")
    `NOPOC_ASSERT(a_overflow_zero_count, aclk, aresetn, m_valid && m_overflow |-> m_occurrence_count == '0, "overflow result carries a nonzero count")
    `NOPOC_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input accepted while a symbol is still walking the levels")
    `NOPOC_ASSERT(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_occurrence_count) && $stable(m_overflow), "stalled result changed")

endmodule

bind nonoverlap_pattern_occurrence_counter nopoc_checker u_nopoc_checker (.*);
